FILE: rtl/fsf_pkg.sv
package fsf_pkg;

	localparam int TIME_W            = 11;
	localparam int FSF_MAX_INTERVALS = 32;
	localparam int CFG_IDX_W         = 3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MY_START    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MY_END      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_OTHER_START = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OTHER_END   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LENGTH  = 3'd4;

	// configuration reset values
	localparam logic [TIME_W-1:0] RST_DAY_START  = 11'd0;
	localparam logic [TIME_W-1:0] RST_DAY_END    = 11'd1439;
	localparam logic [TIME_W-1:0] RST_MIN_LENGTH = 11'd30;

	typedef logic [TIME_W-1:0] time_t;

	// one busy interval held in a cell
	typedef struct packed {
		time_t t_start;
		time_t t_end;
	} iv_t;

	// one result transaction
	typedef struct packed {
		time_t t_start;
		time_t t_end;
		logic  no_slot;
		logic  dropped;
		logic  last;
	} res_t;

	// commands from the loader to the walk unit
	typedef struct packed {
		logic start;
		logic empty;
		logic dropped;
	} walk_cmd_t;

	// status from the walk unit back to the loader
	typedef struct packed {
		logic busy;
		logic shift;
		logic done;
	} walk_sts_t;

	function automatic res_t mk_res(time_t s, time_t e, logic none, logic drop, logic last);
		res_t r;
		r.t_start = s;
		r.t_end   = e;
		r.no_slot = none;
		r.dropped = drop;
		r.last    = last;
		return r;
	endfunction

endpackage

FILE: rtl/fsf_if.sv
interface fsf_busy_if;
	import fsf_pkg::*;
	logic  valid;
	logic  ready;
	time_t busy_start;
	time_t busy_end;
	logic  last_busy;
	modport source (output valid, busy_start, busy_end, last_busy, input ready);
	modport sink (input valid, busy_start, busy_end, last_busy, output ready);
endinterface

interface fsf_slot_if;
	import fsf_pkg::*;
	logic  valid;
	logic  ready;
	time_t slot_start;
	time_t slot_end;
	logic  no_slot;
	logic  dropped;
	logic  last_slot;
	modport source (output valid, slot_start, slot_end, no_slot, dropped, last_slot,
		input ready);
	modport sink (input valid, slot_start, slot_end, no_slot, dropped, last_slot,
		output ready);
endinterface

interface fsf_cfg_if;
	import fsf_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [TIME_W-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: rtl/fsf_cell.sv
module fsf_cell (
	input  logic         clk,
	input  logic         ins_en,
	input  logic         shift,
	input  logic         occ,
	input  fsf_pkg::iv_t new_iv,
	input  logic         left_g,
	input  fsf_pkg::iv_t left_iv,
	input  fsf_pkg::iv_t right_iv,
	output logic         g,
	output fsf_pkg::iv_t iv_q
);
	import fsf_pkg::*;

	logic gt;

	// held interval sorts after the incoming one
	assign gt = (iv_q.t_start > new_iv.t_start) ||
		((iv_q.t_start == new_iv.t_start) && (iv_q.t_end > new_iv.t_end));
	assign g = !occ || gt;

	// walk shifts toward the head, insertion shifts toward the tail
	always_ff @(posedge clk) begin
		if (shift) begin
			iv_q <= right_iv;
		end else if (ins_en) begin
			if (left_g) begin
				iv_q <= left_iv;
			end else if (g) begin
				iv_q <= new_iv;
			end
		end
	end

endmodule

FILE: rtl/fsf_walk.sv
module fsf_walk (
	input  logic               clk,
	input  logic               arst_n,
	input  fsf_pkg::walk_cmd_t cmd,
	input  fsf_pkg::time_t     run_start,
	input  fsf_pkg::time_t     day_end,
	input  fsf_pkg::time_t     min_len,
	input  fsf_pkg::iv_t       head,
	output fsf_pkg::walk_sts_t sts,
	fsf_slot_if.source         slot
);
	import fsf_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_WALK  = 2'd1;
	localparam logic [1:0] ST_FINAL = 2'd2;
	localparam logic [1:0] ST_FLUSH = 2'd3;

	logic [1:0] state_q, state_d;
	time_t      run_q, run_d;
	res_t       pend_q, pend_d, out_q;
	logic       pend_v_q, pend_v_d, out_v_q;
	logic       out_load, pend_load, out_free;
	logic       gap_ok, fin_ok;
	time_t      new_run;

	assign out_free = !out_v_q || slot.ready;

	// gap before the head interval, final gap up to the day end
	assign gap_ok  = (run_q < head.t_start) && ((head.t_start - run_q) >= min_len);
	assign new_run = (head.t_end > run_q) ? head.t_end : run_q;
	assign fin_ok  = (day_end >= run_q) && ((day_end - run_q) >= min_len);

	// sequencer: one stored interval per step; a slot waits in pend until
	// it is known whether another result follows
	always_comb begin
		state_d   = state_q;
		run_d     = run_q;
		pend_d    = pend_q;
		pend_v_d  = pend_v_q;
		out_load  = 1'b0;
		pend_load = 1'b0;
		sts       = '0;
		case (state_q)
			ST_IDLE: begin
				if (cmd.start) begin
					run_d   = run_start;
					state_d = ST_WALK;
				end
			end
			ST_WALK: begin
				if (cmd.empty) begin
					state_d = ST_FINAL;
				end else if (out_free) begin
					sts.shift = 1'b1;
					run_d     = new_run;
					if (gap_ok) begin
						out_load  = pend_v_q;
						pend_load = 1'b1;
						pend_v_d  = 1'b1;
						pend_d    = mk_res(run_q, head.t_start, 1'b0, cmd.dropped, 1'b0);
					end
				end
			end
			ST_FINAL: begin
				if (out_free) begin
					state_d   = ST_FLUSH;
					pend_load = 1'b1;
					pend_v_d  = 1'b1;
					if (fin_ok) begin
						out_load = pend_v_q;
						pend_d   = mk_res(run_q, day_end, 1'b0, cmd.dropped, 1'b1);
					end else if (pend_v_q) begin
						pend_d      = pend_q;
						pend_d.last = 1'b1;
					end else begin
						pend_d = mk_res('0, '0, 1'b1, cmd.dropped, 1'b1);
					end
				end
			end
			ST_FLUSH: begin
				if (out_free) begin
					out_load = 1'b1;
					pend_v_d = 1'b0;
					state_d  = ST_IDLE;
					sts.done = 1'b1;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
		sts.busy = (state_q != ST_IDLE);
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			run_q    <= '0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			state_q  <= state_d;
			run_q    <= run_d;
			pend_v_q <= pend_v_d;
			if (out_load) begin
				out_v_q <= 1'b1;
			end else if (slot.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	// pending and output payload
	always_ff @(posedge clk) begin
		if (pend_load) begin
			pend_q <= pend_d;
		end
		if (out_load) begin
			out_q <= pend_q;
		end
	end

	assign slot.valid      = out_v_q;
	assign slot.slot_start = out_q.t_start;
	assign slot.slot_end   = out_q.t_end;
	assign slot.no_slot    = out_q.no_slot;
	assign slot.dropped    = out_q.dropped;
	assign slot.last_slot  = out_q.last;

endmodule

FILE: rtl/common_free_slot_finder.sv
// loading: one busy interval accepted per cycle, sorted in place by the cell chain
// walk: starts the cycle after the final interval; one stored interval per cycle
//   leaves through the head cell while the output is not stalled; the final and
//   flush states follow, and the last result turns valid as the input reopens
// results leave through an output register; a stalled output holds the walk
// reset clears the interval count, overflow flag, sequencer and config registers;
//   cell contents are not cleared
module common_free_slot_finder #(
	parameter int MAX_INTERVALS = fsf_pkg::FSF_MAX_INTERVALS
) (
	input  logic       clk,
	input  logic       arst_n,
	fsf_busy_if.sink   busy,
	fsf_slot_if.source slot,
	fsf_cfg_if.sink    cfg
);
	import fsf_pkg::*;

	localparam int CNT_W = $clog2(MAX_INTERVALS + 1);

	time_t      my_start_q, my_end_q, other_start_q, other_end_q, min_len_q;
	logic [CNT_W-1:0] cnt_q;
	logic       ovf_q;
	logic       acc, full, ins_en;
	iv_t        new_iv;
	time_t      run_start, day_end;
	walk_cmd_t  cmd;
	walk_sts_t  sts;
	iv_t        cell_iv [MAX_INTERVALS];
	logic       cell_g  [MAX_INTERVALS];
	logic       occ     [MAX_INTERVALS];

	// configuration writes
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_start_q    <= RST_DAY_START;
			my_end_q      <= RST_DAY_END;
			other_start_q <= RST_DAY_START;
			other_end_q   <= RST_DAY_END;
			min_len_q     <= RST_MIN_LENGTH;
		end else if (cfg.valid && cfg.ready) begin
			case (cfg.index)
				CFG_MY_START:    my_start_q    <= cfg.data;
				CFG_MY_END:      my_end_q      <= cfg.data;
				CFG_OTHER_START: other_start_q <= cfg.data;
				CFG_OTHER_END:   other_end_q   <= cfg.data;
				CFG_MIN_LENGTH:  min_len_q     <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	assign run_start = (my_start_q > other_start_q) ? my_start_q : other_start_q;
	assign day_end   = (my_end_q < other_end_q) ? my_end_q : other_end_q;

	// input side; an inverted interval ends at its start
	assign busy.ready     = !sts.busy;
	assign acc            = busy.valid && busy.ready;
	assign full           = (cnt_q == CNT_W'(MAX_INTERVALS));
	assign ins_en         = acc && !full;
	assign new_iv.t_start = busy.busy_start;
	assign new_iv.t_end   = (busy.busy_end < busy.busy_start) ? busy.busy_start
		: busy.busy_end;

	// interval count and overflow flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			if (ins_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (sts.shift) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (acc && full) begin
				ovf_q <= 1'b1;
			end else if (sts.done) begin
				ovf_q <= 1'b0;
			end
		end
	end

	// sorted cell chain
	for (genvar i = 0; i < MAX_INTERVALS; i++) begin : g_cell
		assign occ[i] = (CNT_W'(i) < cnt_q);
		fsf_cell u_cell (
			.clk      (clk),
			.ins_en   (ins_en),
			.shift    (sts.shift),
			.occ      (occ[i]),
			.new_iv   (new_iv),
			.left_g   ((i == 0) ? 1'b0 : cell_g[(i == 0) ? 0 : i - 1]),
			.left_iv  ((i == 0) ? new_iv : cell_iv[(i == 0) ? 0 : i - 1]),
			.right_iv (cell_iv[(i == MAX_INTERVALS - 1) ? i : i + 1]),
			.g        (cell_g[i]),
			.iv_q     (cell_iv[i])
		);
	end

	// walk over the chain head
	assign cmd.start   = acc && busy.last_busy;
	assign cmd.empty   = (cnt_q == '0);
	assign cmd.dropped = ovf_q;

	fsf_walk u_walk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.run_start (run_start),
		.day_end   (day_end),
		.min_len   (min_len_q),
		.head      (cell_iv[0]),
		.sts       (sts),
		.slot      (slot)
	);

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_INTERVALS))
		else $error("interval count above capacity");

	a_no_ins_walk: assert property (@(posedge clk) disable iff (!arst_n)
		!(ins_en && sts.shift))
		else $error("insert during walk");

	a_last_locks: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && busy.last_busy) |=> !busy.ready)
		else $error("input still open after final interval");

	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> (full || sts.busy))
		else $error("overflow flag without full store");

	a_shift_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		sts.shift |-> (cnt_q != '0))
		else $error("walk step on empty chain");

endmodule

FILE: verif/tb_common_free_slot_finder.sv
`timescale 1ns / 1ps

module tb_common_free_slot_finder;
	import fsf_pkg::*;

	localparam int CYCLE_LIMIT = 500000;
	localparam int SETTLE      = FSF_MAX_INTERVALS + 16;
	localparam int RAND_ITEMS  = 400;
	localparam int HOLD_CYCLES = 400;

	// unused register index on interval rows of the directed table
	localparam logic [CFG_IDX_W-1:0] IDX_NONE = CFG_MY_START;

	localparam logic [CFG_IDX_W-1:0] REG_ORDER [5] = '{CFG_MY_START, CFG_MY_END,
		CFG_OTHER_START, CFG_OTHER_END, CFG_MIN_LENGTH};

	// results that can be read off directly
	localparam res_t FULL_DAY = '{11'd0, 11'd1439, 1'b0, 1'b0, 1'b1};
	localparam res_t NO_FREE  = '{11'd0, 11'd0, 1'b1, 1'b0, 1'b1};

	typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

	typedef struct packed {
		row_kind_e            kind;
		logic [CFG_IDX_W-1:0] idx;
		time_t                a;
		time_t                b;
		logic                 last;
		logic                 typed;
		res_t                 exp;
	} dir_row_t;

	localparam int DIR_N = 27;

	// directed sequence: interval rows carry start, end, last; register rows carry the value
	dir_row_t dir_tab [DIR_N] = '{
		'{ROW_ITEM, IDX_NONE, 11'd0, 11'd0, 1'b1, 1'b1, FULL_DAY},
		'{ROW_ITEM, IDX_NONE, 11'd0, 11'd1439, 1'b1, 1'b1, NO_FREE},
		'{ROW_ITEM, IDX_NONE, 11'd1439, 11'd1439, 1'b1, 1'b1, FULL_DAY},
		'{ROW_ITEM, IDX_NONE, 11'd500, 11'd100, 1'b1, 1'b0, '0},
		'{ROW_ITEM, IDX_NONE, 11'd600, 11'd700, 1'b0, 1'b0, '0},
		'{ROW_ITEM, IDX_NONE, 11'd100, 11'd200, 1'b0, 1'b0, '0},
		'{ROW_ITEM, IDX_NONE, 11'd100, 11'd150, 1'b0, 1'b0, '0},
		'{ROW_ITEM, IDX_NONE, 11'd650, 11'd900, 1'b0, 1'b0, '0},
		'{ROW_ITEM, IDX_NONE, 11'd210, 11'd230, 1'b1, 1'b0, '0},
		'{ROW_CFG, CFG_MIN_LENGTH, 11'd0, 11'd0, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_MY_END, 11'd1000, 11'd0, 1'b0, 1'b0, '0},
		'{ROW_ITEM, IDX_NONE, 11'd900, 11'd1000, 1'b1, 1'b0, '0},
		'{ROW_ITEM, IDX_NONE, 11'd0, 11'd1000, 1'b1, 1'b0, '0},
		'{ROW_CFG, CFG_MIN_LENGTH, 11'd1439, 11'd0, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_MY_END, 11'd1439, 11'd0, 1'b0, 1'b0, '0},
		'{ROW_ITEM, IDX_NONE, 11'd5, 11'd10, 1'b1, 1'b1, NO_FREE},
		'{ROW_ITEM, IDX_NONE, 11'd0, 11'd0, 1'b1, 1'b1, FULL_DAY},
		'{ROW_CFG, CFG_MIN_LENGTH, 11'd30, 11'd0, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_MY_START, 11'd800, 11'd0, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_OTHER_END, 11'd700, 11'd0, 1'b0, 1'b0, '0},
		'{ROW_ITEM, IDX_NONE, 11'd0, 11'd0, 1'b1, 1'b1, NO_FREE},
		'{ROW_CFG, CFG_OTHER_START, 11'd900, 11'd0, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_OTHER_END, 11'd1439, 11'd0, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_MY_START, 11'd0, 11'd0, 1'b0, 1'b0, '0},
		'{ROW_ITEM, IDX_NONE, 11'd100, 11'd950, 1'b0, 1'b0, '0},
		'{ROW_ITEM, IDX_NONE, 11'd1000, 11'd1100, 1'b1, 1'b0, '0},
		'{ROW_ITEM, IDX_NONE, 11'd1439, 11'd0, 1'b1, 1'b0, '0}
	};

	logic clk;
	logic arst_n;

	fsf_busy_if busy_ch ();
	fsf_slot_if slot_ch ();
	fsf_cfg_if  cfg_ch ();

	common_free_slot_finder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.busy   (busy_ch),
		.slot   (slot_ch),
		.cfg    (cfg_ch)
	);

	// predictor state
	time_t held_start [FSF_MAX_INTERVALS];
	time_t held_end [FSF_MAX_INTERVALS];
	int    held_cnt;
	logic  held_drop;
	time_t reg_val [0:4];

	res_t walk_q[$];
	res_t slot_exp_q[$];

	int fail_cnt;
	int cycle_cnt;
	bit hold_req;
	bit hold_done;

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// sorted insert of one interval; on the final one, walk the set into walk_q
	function automatic void predict_free_slots(time_t s, time_t e, logic last);
		int    pos;
		time_t run_end;
		time_t day_end;
		res_t  r;
		walk_q.delete();
		if (e < s)
			e = s;
		if (held_cnt >= FSF_MAX_INTERVALS) begin
			held_drop = 1'b1;
		end else begin
			pos = held_cnt;
			while (pos > 0 && (held_start[pos-1] > s ||
					(held_start[pos-1] == s && held_end[pos-1] > e))) begin
				held_start[pos] = held_start[pos-1];
				held_end[pos]   = held_end[pos-1];
				pos--;
			end
			held_start[pos] = s;
			held_end[pos]   = e;
			held_cnt++;
		end
		if (!last)
			return;
		run_end = (reg_val[CFG_MY_START] > reg_val[CFG_OTHER_START]) ?
			reg_val[CFG_MY_START] : reg_val[CFG_OTHER_START];
		day_end = (reg_val[CFG_MY_END] < reg_val[CFG_OTHER_END]) ?
			reg_val[CFG_MY_END] : reg_val[CFG_OTHER_END];
		for (int i = 0; i < held_cnt; i++) begin
			if (run_end < held_start[i] &&
					time_t'(held_start[i] - run_end) >= reg_val[CFG_MIN_LENGTH]) begin
				r = '{run_end, held_start[i], 1'b0, held_drop, 1'b0};
				walk_q.insert(walk_q.size(), r);
			end
			if (held_end[i] > run_end)
				run_end = held_end[i];
		end
		if (day_end >= run_end && time_t'(day_end - run_end) >= reg_val[CFG_MIN_LENGTH]) begin
			r = '{run_end, day_end, 1'b0, held_drop, 1'b0};
			walk_q.insert(walk_q.size(), r);
		end
		if (walk_q.size() == 0) begin
			r = '{11'd0, 11'd0, 1'b1, held_drop, 1'b0};
			walk_q.insert(walk_q.size(), r);
		end
		r = walk_q[walk_q.size()-1];
		r.last = 1'b1;
		walk_q[walk_q.size()-1] = r;
		held_cnt  = 0;
		held_drop = 1'b0;
	endfunction

	// gap before the next transaction: mostly none, some short, a few long
	function automatic int rand_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(5, 40);
	endfunction

	// minute of day with extra weight on the ends of the day
	function automatic time_t pick_minute();
		int r;
		r = $urandom_range(0, 99);
		if (r < 5)
			return 11'd0;
		if (r < 10)
			return 11'd1439;
		return time_t'($urandom_range(0, 1439));
	endfunction

	// offer one interval, predict on acceptance, then idle for the given gap
	task automatic send_interval(time_t s, time_t e, logic last, int gap, logic typed,
			res_t typed_res);
		busy_ch.valid      <= 1'b1;
		busy_ch.busy_start <= s;
		busy_ch.busy_end   <= e;
		busy_ch.last_busy  <= last;
		do @(posedge clk); while (!busy_ch.ready);
		predict_free_slots(s, e, last);
		if (typed)
			slot_exp_q.insert(slot_exp_q.size(), typed_res);
		else
			foreach (walk_q[i])
				slot_exp_q.insert(slot_exp_q.size(), walk_q[i]);
		if (gap > 0) begin
			busy_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// register write; valid stays high until the caller lowers it
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, time_t v);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= v;
		do @(posedge clk); while (!cfg_ch.ready);
		reg_val[idx] = v;
	endtask

	// stop offering until every expected slot has arrived and the walk has settled
	task automatic wait_drained();
		busy_ch.valid <= 1'b0;
		while (slot_exp_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// cycle limit
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("[common_free_slot_finder] ERROR");
		$finish;
	end

	// slot receiver: random stalls, quiet stretches, one long hold; checks each transaction
	initial begin
		int   r;
		int   stall_cnt;
		int   quiet_cnt;
		res_t want;
		slot_ch.ready = 1'b0;
		stall_cnt     = 0;
		quiet_cnt     = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (slot_ch.valid && slot_ch.ready) begin
				if (slot_exp_q.size() == 0) begin
					$error("slot transaction with none expected: start %0d end %0d no_slot %0b",
						slot_ch.slot_start, slot_ch.slot_end, slot_ch.no_slot);
					fail_cnt++;
				end else begin
					want = slot_exp_q.pop_front();
					if (slot_ch.slot_start !== want.t_start) begin
						$error("slot_start: expected %0d, actual %0d", want.t_start,
							slot_ch.slot_start);
						fail_cnt++;
					end
					if (slot_ch.slot_end !== want.t_end) begin
						$error("slot_end: expected %0d, actual %0d", want.t_end, slot_ch.slot_end);
						fail_cnt++;
					end
					if (slot_ch.no_slot !== want.no_slot) begin
						$error("no_slot: expected %0b, actual %0b", want.no_slot, slot_ch.no_slot);
						fail_cnt++;
					end
					if (slot_ch.dropped !== want.dropped) begin
						$error("dropped: expected %0b, actual %0b", want.dropped, slot_ch.dropped);
						fail_cnt++;
					end
					if (slot_ch.last_slot !== want.last) begin
						$error("last_slot: expected %0b, actual %0b", want.last, slot_ch.last_slot);
						fail_cnt++;
					end
				end
			end
			if (hold_req && !hold_done) begin
				hold_done = 1'b1;
				stall_cnt = HOLD_CYCLES;
			end
			if (stall_cnt > 0) begin
				slot_ch.ready <= 1'b0;
				stall_cnt--;
			end else begin
				slot_ch.ready <= 1'b1;
				if (quiet_cnt > 0) begin
					quiet_cnt--;
				end else begin
					r = $urandom_range(0, 99);
					if (r < 2)
						quiet_cnt = $urandom_range(50, 200);
					else if (r < 17)
						stall_cnt = $urandom_range(1, 3);
					else if (r < 20)
						stall_cnt = $urandom_range(5, 40);
				end
			end
		end
	end

	// stimulus
	initial begin
		int    items_sent;
		int    set_idx;
		int    set_len;
		int    span;
		int    base;
		int    r;
		bit    burst;
		bit    prev_cfg;
		time_t s;
		time_t e;
		time_t v;

		clk                = 1'b0;
		arst_n             = 1'b0;
		busy_ch.valid      = 1'b0;
		busy_ch.busy_start = '0;
		busy_ch.busy_end   = '0;
		busy_ch.last_busy  = 1'b0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.index       = CFG_MY_START;
		cfg_ch.data        = '0;
		fail_cnt           = 0;
		hold_req           = 1'b0;
		hold_done          = 1'b0;
		held_cnt           = 0;
		held_drop          = 1'b0;
		reg_val[CFG_MY_START]    = RST_DAY_START;
		reg_val[CFG_MY_END]      = RST_DAY_END;
		reg_val[CFG_OTHER_START] = RST_DAY_START;
		reg_val[CFG_OTHER_END]   = RST_DAY_END;
		reg_val[CFG_MIN_LENGTH]  = RST_MIN_LENGTH;

		// reset
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		prev_cfg = 1'b0;
		foreach (dir_tab[i]) begin
			if (dir_tab[i].kind == ROW_CFG) begin
				if (!prev_cfg)
					wait_drained();
				write_reg(dir_tab[i].idx, dir_tab[i].a);
				prev_cfg = 1'b1;
			end else begin
				if (prev_cfg)
					cfg_ch.valid <= 1'b0;
				send_interval(dir_tab[i].a, dir_tab[i].b, dir_tab[i].last, rand_gap(),
					dir_tab[i].typed, dir_tab[i].exp);
				prev_cfg = 1'b0;
			end
		end

		// random sets
		items_sent = 0;
		set_idx    = 0;
		while (items_sent < RAND_ITEMS) begin
			// new register settings between sets, once the block is idle
			if (set_idx >= 12 && set_idx % 9 == 0) begin
				wait_drained();
				foreach (REG_ORDER[j]) begin
					if (REG_ORDER[j] == CFG_MIN_LENGTH) begin
						r = $urandom_range(0, 99);
						if (r < 12)
							v = 11'd0;
						else if (r < 18)
							v = 11'd1439;
						else if (r < 80)
							v = time_t'($urandom_range(1, 60));
						else
							v = time_t'($urandom_range(0, 1439));
					end else begin
						v = pick_minute();
					end
					write_reg(REG_ORDER[j], v);
				end
				cfg_ch.valid <= 1'b0;
			end else if (set_idx == 20) begin
				wait_drained();
			end

			// first set overflows the store while the receiver holds off
			if (set_idx == 0) begin
				hold_req = 1'b1;
				set_len  = FSF_MAX_INTERVALS + 1;
			end else begin
				r = $urandom_range(0, 99);
				set_len = (r < 8) ? $urandom_range(30, 40) : $urandom_range(1, 8);
			end

			// some sets cluster into a narrow window so intervals overlap
			if ($urandom_range(0, 3) == 0) begin
				base = $urandom_range(0, 1139);
				span = 300;
			end else begin
				base = 0;
				span = 1439;
			end
			burst = ($urandom_range(0, 3) == 0);

			for (int k = 0; k < set_len; k++) begin
				if (span == 1439)
					s = pick_minute();
				else
					s = time_t'(base + $urandom_range(0, span));
				if ($urandom_range(0, 9) == 0) begin
					e = pick_minute();
				end else begin
					r = int'(s) + $urandom_range(0, 150);
					e = time_t'((r > 1439) ? 1439 : r);
				end
				send_interval(s, e, (k == set_len - 1), burst ? 0 : rand_gap(), 1'b0, '0);
				items_sent++;
			end
			set_idx++;
		end

		// wait for the last slots, then report
		wait_drained();
		if (slot_exp_q.size() != 0) begin
			$error("%0d expected slot transactions never arrived", slot_exp_q.size());
			fail_cnt++;
		end
		if (fail_cnt == 0)
			$display("[common_free_slot_finder] OK");
		else
			$display("[common_free_slot_finder] ERROR");
		$finish;
	end

endmodule
